FILE: sv/assert_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check prop on every rising edge of clk_s, ignored while rst_s is low.
`define TPDF_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Check that expr never holds on a rising edge of clk_s.
`define TPDF_NEVER(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);

`else

`define TPDF_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TPDF_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

FILE: sv/tpdf_pkg.sv
package tpdf_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX = 7'd127;
    localparam logic [POS_W-1:0] POS_ETH_HI = 7'd12;
    localparam logic [POS_W-1:0] POS_ETH_LO = 7'd13;
    localparam logic [POS_W-1:0] POS_IHL = 7'd14;
    localparam logic [POS_W-1:0] POS_PROTO = 7'd23;
    localparam logic [POS_W-1:0] PORT_BASE = 7'd16;
    localparam logic [7:0] MIN_TCP_FRAME = 8'd34;

    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TABLE = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        ITEM_WRITE = 1'b0,
        ITEM_VERDICT = 1'b1
    } item_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } back_state_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [15:0] port;
        logic        tcp;
        logic [7:0]  index;
        logic        valid;
        logic        deny;
    } cmd_item_t;

endpackage

FILE: sv/tpdf_front.sv
`include "assert_macros.svh"

module tpdf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                command,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [7:0]          entry_index,
    input  logic [15:0]         entry_port,
    input  logic                entry_valid,
    input  logic                entry_deny,
    output logic                q_wr,
    output tpdf_pkg::cmd_item_t q_item
);
    import tpdf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      et_reg, et_next;
    logic [3:0]       hw_reg, hw_next;
    logic [7:0]       prot_reg, prot_next;
    logic [15:0]      cp_reg, cp_next;

    logic [POS_W-1:0] port_at;
    logic [7:0]       frame_len;
    logic [7:0]       need_len;
    logic             tcp;
    logic             beat;
    logic             is_table;

    assign beat = push && !full;
    assign is_table = (cmd_kind_t'(command) == CMD_TABLE);

    always_comb
    begin
        et_next = et_reg;
        hw_next = hw_reg;
        prot_next = prot_reg;
        cp_next = cp_reg;
        port_at = PORT_BASE + {1'b0, hw_reg, 2'b00};

        if (pos_reg == POS_ETH_HI)
            et_next[15:8] = data_byte;
        else if (pos_reg == POS_ETH_LO)
            et_next[7:0] = data_byte;
        else if (pos_reg == POS_IHL)
            hw_next = data_byte[3:0];
        else if (pos_reg == POS_PROTO)
            prot_next = data_byte;

        if (pos_reg == port_at)
            cp_next[15:8] = data_byte;
        else if (pos_reg == port_at + 7'd1)
            cp_next[7:0] = data_byte;

        frame_len = {1'b0, pos_reg} + 8'd1;
        need_len = MIN_TCP_FRAME + {2'b00, hw_next, 2'b00};
        tcp = (et_next == IPV4_ETHERTYPE) && (prot_next == TCP_PROTOCOL)
            && (frame_len >= need_len);

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            et_reg <= '0;
            hw_reg <= '0;
            prot_reg <= '0;
            cp_reg <= '0;
        end
        else if (beat && !is_table)
        begin
            if (last_byte)
            begin
                // Frame done: return to a clean frame state
                pos_reg <= '0;
                et_reg <= '0;
                hw_reg <= '0;
                prot_reg <= '0;
                cp_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                et_reg <= et_next;
                hw_reg <= hw_next;
                prot_reg <= prot_next;
                cp_reg <= cp_next;
            end
        end
    end

    always_comb
    begin
        q_wr = beat && (is_table || last_byte);
        q_item.kind = is_table ? ITEM_WRITE : ITEM_VERDICT;
        q_item.port = is_table ? entry_port : (tcp ? cp_next : 16'd0);
        q_item.tcp = tcp;
        q_item.index = entry_index;
        q_item.valid = entry_valid;
        q_item.deny = entry_deny;
    end

    `TPDF_ASSERT(a_frame_clear, clk, rst_n, q_wr && q_item.kind == ITEM_VERDICT |=> pos_reg == '0, "frame state not cleared after last byte")

endmodule

FILE: sv/tpdf_cmd_queue.sv
`include "assert_macros.svh"

module tpdf_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  tpdf_pkg::cmd_item_t wr_item,
    output logic                full,
    input  logic                rd,
    output logic                empty,
    output tpdf_pkg::cmd_item_t head
);
    import tpdf_pkg::*;

    cmd_item_t           mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wp_reg, rp_reg;
    logic [CQ_CNT_W-1:0] count_reg;

    assign full = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    `TPDF_NEVER(a_cq_overflow, clk, rst_n, wr && full && !rd, "command queue written while full")
    `TPDF_NEVER(a_cq_underflow, clk, rst_n, rd && empty, "command queue read while empty")

endmodule

FILE: sv/tpdf_back.sv
`include "assert_macros.svh"

module tpdf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tpdf_pkg::cmd_item_t q_head,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic                verdict,
    output logic [15:0]         dst_port,
    output logic                tcp_seen
);
    import tpdf_pkg::*;

    // Port table: valid bits reset, {deny, port} words live in a memory
    logic [TABLE_ENTRIES-1:0] tbl_valid_reg;
    logic [16:0]              tbl_word_reg [TABLE_ENTRIES];

    logic             write_pop;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_in_range;

    // Lookup scan: one table read per cycle, lowest slot first
    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             issue_reg, issue_next;
    logic [15:0]      key_reg, key_next;
    logic             rd_en;
    logic             chk_reg;
    logic             chk_last_reg;
    logic             rd_valid_reg;
    logic [16:0]      rd_word_reg;
    logic             hit;

    // Result queue
    logic                verdict_mem_reg [OQ_DEPTH];
    logic                tcp_mem_reg [OQ_DEPTH];
    logic [15:0]         port_mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wp_reg, oq_rp_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg;
    logic                oq_full;
    logic                oq_wr;
    logic                oq_rd;
    logic                res_verdict;
    logic [15:0]         res_port;
    logic                res_tcp;

    assign wr_idx = IDX_W'(q_head.index);
    assign wr_in_range = (32'(q_head.index) < 32'(TABLE_ENTRIES));
    assign oq_full = (oq_count_reg == OQ_CNT_W'(OQ_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        issue_next = issue_reg;
        key_next = key_reg;
        q_rd = 1'b0;
        write_pop = 1'b0;
        oq_wr = 1'b0;
        res_verdict = 1'b0;
        res_port = 16'd0;
        res_tcp = 1'b0;
        rd_en = (state_reg == BK_SCAN) && issue_reg;
        hit = chk_reg && rd_valid_reg && (rd_word_reg[15:0] == key_reg);

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == ITEM_WRITE)
                    begin
                        q_rd = 1'b1;
                        write_pop = 1'b1;
                    end
                    else if (!oq_full)
                    begin
                        // Hold a result slot from here until the scan ends
                        q_rd = 1'b1;
                        if (q_head.tcp)
                        begin
                            key_next = q_head.port;
                            addr_next = '0;
                            issue_next = 1'b1;
                            state_next = BK_SCAN;
                        end
                        else
                        begin
                            oq_wr = 1'b1;
                            res_port = q_head.port;
                        end
                    end
                end
            end
            BK_SCAN:
            begin
                if (issue_reg)
                begin
                    addr_next = addr_reg + 1'b1;
                    issue_next = (addr_reg != LAST_IDX);
                end
                // Stop at the first valid match or after the last slot
                if (hit || (chk_reg && chk_last_reg))
                begin
                    oq_wr = 1'b1;
                    res_verdict = hit && rd_word_reg[16];
                    res_port = key_reg;
                    res_tcp = 1'b1;
                    issue_next = 1'b0;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                issue_next = 1'b0;
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            addr_reg <= '0;
            issue_reg <= 1'b0;
            key_reg <= '0;
            chk_reg <= 1'b0;
            chk_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            issue_reg <= issue_next;
            key_reg <= key_next;
            chk_reg <= rd_en && (state_next == BK_SCAN);
            chk_last_reg <= (addr_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tbl_valid_reg <= '0;
        else if (write_pop && wr_in_range)
            tbl_valid_reg[wr_idx] <= q_head.valid;
    end

    always_ff @(posedge clk)
    begin
        if (write_pop && wr_in_range)
            tbl_word_reg[wr_idx] <= {q_head.deny, q_head.port};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= tbl_word_reg[addr_reg];
            rd_valid_reg <= tbl_valid_reg[addr_reg];
        end
    end

    assign oq_rd = pop && !empty;
    assign empty = (oq_count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            verdict_mem_reg[oq_wp_reg] <= res_verdict;
            tcp_mem_reg[oq_wp_reg] <= res_tcp;
            port_mem_reg[oq_wp_reg] <= res_port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg <= '0;
            oq_rp_reg <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_wr)
                oq_wp_reg <= oq_wp_reg + 1'b1;
            if (oq_rd)
                oq_rp_reg <= oq_rp_reg + 1'b1;
            if (oq_wr && !oq_rd)
                oq_count_reg <= oq_count_reg + 1'b1;
            else if (oq_rd && !oq_wr)
                oq_count_reg <= oq_count_reg - 1'b1;
        end
    end

    assign verdict = verdict_mem_reg[oq_rp_reg];
    assign tcp_seen = tcp_mem_reg[oq_rp_reg];
    assign dst_port = port_mem_reg[oq_rp_reg];

    `TPDF_NEVER(a_oq_overflow, clk, rst_n, oq_wr && oq_full && !oq_rd, "result queue overflow")
    `TPDF_ASSERT(a_scan_tail, clk, rst_n, state_reg != BK_SCAN || issue_reg || (chk_reg && chk_last_reg), "lookup scan ran past the last slot")

endmodule

FILE: sv/tcp_port_deny_filter.sv
// TCP destination-port deny filter. Push one beat per cycle: a frame byte (command 0) or a
// port table write (command 1); table writes take effect in order with frame beats and
// yield no result. Each frame gives one result after its last byte: tcp_seen when the
// frame is IPv4 TCP with a whole TCP header, dst_port the captured port (zero otherwise),
// and verdict 1 when the lowest-index valid table entry holding that port says deny.
// The front parses bytes at one beat per clock while full is low and passes table writes
// and frame ends through a four-entry command queue. The back applies a table write as it
// pops it and, for a TCP frame, scans the table one slot per cycle from slot 0, stopping at
// the first valid match. A non-TCP result is queued as its frame end is popped, a TCP
// result once the scan stops. During a scan later beats wait in the command queue; once it
// fills, full holds the input. The table is empty right after reset, with no clearing pass.
`include "assert_macros.svh"

module tcp_port_deny_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_port,
    input  logic        entry_valid,
    input  logic        entry_deny,
    output logic        empty,
    input  logic        pop,
    output logic        verdict,
    output logic [15:0] dst_port,
    output logic        tcp_seen
);
    import tpdf_pkg::*;

    logic      q_wr;
    logic      q_rd;
    logic      q_empty;
    cmd_item_t q_wr_item;
    cmd_item_t q_head;

    tpdf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .entry_index (entry_index),
        .entry_port  (entry_port),
        .entry_valid (entry_valid),
        .entry_deny  (entry_deny),
        .q_wr        (q_wr),
        .q_item      (q_wr_item)
    );

    tpdf_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_wr_item),
        .full    (full),
        .rd      (q_rd),
        .empty   (q_empty),
        .head    (q_head)
    );

    tpdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .verdict   (verdict),
        .dst_port  (dst_port),
        .tcp_seen  (tcp_seen)
    );

    `TPDF_NEVER(a_result_no_tcp_drop, clk, rst_n, !empty && verdict && !tcp_seen, "drop verdict on non-TCP frame")

endmodule

FILE: dv/tcp_port_deny_filter_checker.sv
module tcp_port_deny_filter_checker
    import tpdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_port,
    input  logic        entry_valid,
    input  logic        entry_deny,
    input  logic        empty,
    input  logic        pop,
    input  logic        verdict,
    input  logic [15:0] dst_port,
    input  logic        tcp_seen,
    output int          mismatches,
    output int          pending,
    output int          verdicts,
    output int          tcp_frames,
    output int          drops
);

    typedef struct packed {
        logic        drop;
        logic [15:0] port;
        logic        tcp;
    } frame_verdict_t;

    frame_verdict_t verdict_q[$];

    // per-frame parse state
    logic [POS_W-1:0] pos_q;
    logic [15:0]      eth_q;
    logic [3:0]       ihl_q;
    logic [7:0]       proto_q;
    logic [15:0]      port_q;

    logic             deny_valid [TABLE_ENTRIES];
    logic             deny_bit   [TABLE_ENTRIES];
    logic [15:0]      deny_port  [TABLE_ENTRIES];

    int err_cnt;
    int verdict_cnt;
    int tcp_cnt;
    int drop_cnt;

    // lowest-index valid entry holding the key decides
    function automatic logic port_denied(input logic [15:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (deny_valid[i] && deny_port[i] == key)
                return deny_bit[i];
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_verdict_t want;
        int             port_at;
        int             length;
        logic           tcp;
        logic [15:0]    key;
        if (!rst_n)
        begin
            pos_q   = '0;
            eth_q   = '0;
            ihl_q   = '0;
            proto_q = '0;
            port_q  = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                deny_valid[i] = 1'b0;
                deny_bit[i]   = 1'b0;
                deny_port[i]  = '0;
            end
            verdict_q.delete();
            err_cnt     = 0;
            verdict_cnt = 0;
            tcp_cnt     = 0;
            drop_cnt    = 0;
            mismatches <= 0;
            pending    <= 0;
            verdicts   <= 0;
            tcp_frames <= 0;
            drops      <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                if (command == CMD_TABLE)
                begin
                    if (int'(entry_index) < TABLE_ENTRIES)
                    begin
                        deny_valid[entry_index] = entry_valid;
                        deny_bit[entry_index]   = entry_deny;
                        deny_port[entry_index]  = entry_port;
                    end
                end
                else
                begin
                    port_at = int'(PORT_BASE) + 4 * int'(ihl_q);
                    case (pos_q)
                        POS_ETH_HI: eth_q[15:8] = data_byte;
                        POS_ETH_LO: eth_q[7:0]  = data_byte;
                        POS_IHL:    ihl_q       = data_byte[3:0];
                        POS_PROTO:  proto_q     = data_byte;
                        default: ;
                    endcase
                    if (int'(pos_q) >= int'(PORT_BASE) && int'(pos_q) == port_at)
                        port_q[15:8] = data_byte;
                    else if (int'(pos_q) > int'(PORT_BASE) && int'(pos_q) == port_at + 1)
                        port_q[7:0] = data_byte;

                    if (!last_byte)
                    begin
                        // position saturates; all captured bytes lie well below it
                        if (pos_q < POS_MAX)
                            pos_q = pos_q + 1'b1;
                    end
                    else
                    begin
                        length = int'(pos_q) + 1;
                        tcp = eth_q == IPV4_ETHERTYPE && proto_q == TCP_PROTOCOL &&
                              length >= int'(MIN_TCP_FRAME) + 4 * int'(ihl_q);
                        key = tcp ? port_q : 16'h0000;
                        want.tcp  = tcp;
                        want.port = key;
                        want.drop = tcp && port_denied(key);
                        verdict_q.push_back(want);
                        pos_q   = '0;
                        eth_q   = '0;
                        ihl_q   = '0;
                        proto_q = '0;
                        port_q  = '0;
                    end
                end
            end

            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result beat: verdict %0b dst_port %0h tcp_seen %0b",
                             $time, verdict, dst_port, tcp_seen);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    verdict_cnt++;
                    if (want.tcp)
                        tcp_cnt++;
                    if (want.drop)
                        drop_cnt++;
                    if (verdict !== want.drop)
                    begin
                        err_cnt++;
                        $display("%0t: verdict mismatch: expected %0b, actual %0b",
                                 $time, want.drop, verdict);
                    end
                    if (dst_port !== want.port)
                    begin
                        err_cnt++;
                        $display("%0t: dst_port mismatch: expected %0h, actual %0h",
                                 $time, want.port, dst_port);
                    end
                    if (tcp_seen !== want.tcp)
                    begin
                        err_cnt++;
                        $display("%0t: tcp_seen mismatch: expected %0b, actual %0b",
                                 $time, want.tcp, tcp_seen);
                    end
                end
            end

            mismatches <= err_cnt;
            pending    <= verdict_q.size();
            verdicts   <= verdict_cnt;
            tcp_frames <= tcp_cnt;
            drops      <= drop_cnt;
        end
    end

endmodule

FILE: dv/tcp_port_deny_filter_tb.sv
module tcp_port_deny_filter_tb;
    import tpdf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES      = 4;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic        command     = CMD_FRAME;
    logic [7:0]  data_byte   = '0;
    logic        last_byte   = 1'b0;
    logic [7:0]  entry_index = '0;
    logic [15:0] entry_port  = '0;
    logic        entry_valid = 1'b0;
    logic        entry_deny  = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic        verdict;
    logic [15:0] dst_port;
    logic        tcp_seen;

    int mismatches;
    int pending;
    int verdicts;
    int tcp_frames;
    int drops;

    int cycles   = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int beats    = 0;
    int frames   = 0;
    int writes   = 0;

    logic [7:0]  frame_bytes[$];
    logic [15:0] port_pool[8];

    tcp_port_deny_filter i_dut (.*);

    tcp_port_deny_filter_checker i_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // hold the beat until accepted, then idle at the phase's rate
    task automatic send_beat(input cmd_kind_t cmd, input logic [7:0] data, input logic last,
                             input logic [7:0] idx, input logic [15:0] port,
                             input logic valid, input logic deny);
        push        <= 1'b1;
        command     <= cmd;
        data_byte   <= data;
        last_byte   <= last;
        entry_index <= idx;
        entry_port  <= port;
        entry_valid <= valid;
        entry_deny  <= deny;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats++;
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [15:0] port,
                               input logic valid, input logic deny);
        send_beat(CMD_TABLE, 8'($urandom), 1'($urandom), idx, port, valid, deny);
        writes++;
    endtask

    task automatic send_frame(input int len, input logic [15:0] eth, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] port);
        int port_at;
        port_at = int'(PORT_BASE) + 4 * int'(ihl);
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(8'($urandom));
        if (len > int'(POS_ETH_HI))
            frame_bytes[POS_ETH_HI] = eth[15:8];
        if (len > int'(POS_ETH_LO))
            frame_bytes[POS_ETH_LO] = eth[7:0];
        if (len > int'(POS_IHL))
            frame_bytes[POS_IHL] = {frame_bytes[POS_IHL][7:4], ihl};
        if (len > int'(POS_PROTO))
            frame_bytes[POS_PROTO] = proto;
        if (len > port_at)
            frame_bytes[port_at] = port[15:8];
        if (len > port_at + 1)
            frame_bytes[port_at + 1] = port[7:0];
        for (int i = 0; i < len; i++)
            send_beat(CMD_FRAME, frame_bytes[i], i == len - 1, 8'($urandom), 16'($urandom),
                      1'($urandom), 1'($urandom));
        frames++;
    endtask

    function automatic logic [15:0] pick_port();
        if ($urandom_range(9) < 8)
            return port_pool[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    initial
    begin
        int          sender_idle[PHASES];
        int          receiver_stall[PHASES];
        int          pick;
        int          len;
        int          base_beats;
        logic [3:0]  ihl;
        logic [7:0]  idx;
        sender_idle    = '{0, 74, 0, 12};
        receiver_stall = '{0, 0, 74, 12};
        port_pool = '{16'd80, 16'd443, 16'd22, 16'h0000, 16'hFFFF,
                      16'($urandom), 16'($urandom), 16'($urandom)};

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: TCP frame passes
        send_frame(40, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd80);
        write_entry(8'd5, 16'd80, 1'b1, 1'b1);
        send_frame(54, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd80);
        // duplicate key at a lower slot with allow status takes priority
        write_entry(8'd3, 16'd80, 1'b1, 1'b0);
        send_frame(54, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd80);
        // invalid entry never matches
        write_entry(8'd1, 16'd22, 1'b0, 1'b1);
        send_frame(60, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd22);
        write_entry(8'd0, 16'hFFFF, 1'b1, 1'b1);
        write_entry(8'd255, 16'h0000, 1'b1, 1'b1);
        write_entry(8'd254, 16'h0000, 1'b1, 1'b0);
        send_frame(54, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        send_frame(54, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'h0000);
        // one byte short of a whole TCP header, then exactly enough
        send_frame(53, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        send_frame(34, IPV4_ETHERTYPE, 4'd0, TCP_PROTOCOL, 16'hFFFF);
        send_frame(33, IPV4_ETHERTYPE, 4'd0, TCP_PROTOCOL, 16'hFFFF);
        send_frame(94, IPV4_ETHERTYPE, 4'd15, TCP_PROTOCOL, 16'hFFFF);
        send_frame(93, IPV4_ETHERTYPE, 4'd15, TCP_PROTOCOL, 16'hFFFF);
        send_frame(60, 16'h86DD, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        send_frame(60, IPV4_ETHERTYPE, 4'd5, 8'd17, 16'hFFFF);
        // long frame runs the position counter into saturation
        send_frame(200, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        send_frame(1, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        send_frame(13, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);
        write_entry(8'd0, 16'hFFFF, 1'b0, 1'b0);
        send_frame(54, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF);

        base_beats = beats;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            idle_pct  = sender_idle[phase];
            stall_pct = receiver_stall[phase];
            while (beats < base_beats + 120 * (phase + 1))
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    // crowd the low slots so duplicate keys compete
                    idx = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
                    write_entry(idx, pick_port(), $urandom_range(3) != 0, 1'($urandom));
                end
                else if (pick < 85)
                begin
                    ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15));
                    len = int'(MIN_TCP_FRAME) + 4 * int'(ihl);
                    if ($urandom_range(3) != 0)
                        len += $urandom_range(30);
                    send_frame(len, IPV4_ETHERTYPE, ihl, TCP_PROTOCOL, pick_port());
                end
                else
                begin
                    ihl = 4'($urandom);
                    case ($urandom_range(3))
                        0: send_frame($urandom_range(1, int'(MIN_TCP_FRAME) + 4 * int'(ihl) - 1),
                                      IPV4_ETHERTYPE, ihl, TCP_PROTOCOL, pick_port());
                        1: send_frame($urandom_range(34, 100), 16'($urandom), ihl,
                                      TCP_PROTOCOL, pick_port());
                        2: send_frame($urandom_range(34, 100), IPV4_ETHERTYPE, ihl,
                                      8'($urandom), pick_port());
                        default: send_frame($urandom_range(100, 160), IPV4_ETHERTYPE, ihl,
                                            TCP_PROTOCOL, pick_port());
                    endcase
                end
            end
        end
        push <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);

        $display("Checked %0d frame verdicts (%0d TCP, %0d dropped) from %0d beats,",
                 verdicts, tcp_frames, drops, beats);
        $display("with %0d table writes, across back-to-back, stalled and idle traffic", writes);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
